// ===== rtl/core/multi_task_watchdog_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-task watchdog monitor
// Shared property forms, all clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_WATCHDOG_MONITOR_ASSERT_SVH
`define MULTI_TASK_WATCHDOG_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define MTWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog monitor check failed");

// Next-cycle implication.
`define MTWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog monitor check failed");

`endif

// ===== rtl/core/mtwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Watchdog monitor package
// Field widths, operation and cause codes, register indexes and the
// command bundle passed from the input stage to the state modules.
// ----------------------------------------------------------------------------
package mtwd_pkg;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 3;
    localparam int CAUSE_W   = 2;
    localparam int CNT_W     = 16;
    localparam int UPTIME_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_ARM  = 2'd0;
    localparam logic [OP_W-1:0] OP_KICK = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Reset cause codes of a result item.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_SELF    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ENABLE  = 2'd2;

    // Register reset values: five minutes and thirty hours at ten-second ticks.
    localparam logic [CNT_W-1:0]    TIMEOUT_RESET    = CNT_W'(5 * 60 / 10);
    localparam logic [UPTIME_W-1:0] SELF_TICKS_RESET = UPTIME_W'(30 * 60 * 60 / 10);

    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [UPTIME_W-1:0] UPTIME_MAX = '1;

    // Decoded command of the item being processed this cycle.
    typedef struct packed {
        logic              arm;
        logic              kick;
        logic              tick;
        logic [SLOT_W-1:0] slot;
        logic              watch_on;
    } cmd_t;

endpackage

// ===== rtl/core/mtwd_if.sv =====
// ----------------------------------------------------------------------------
// Watchdog monitor channels
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface mtwd_event_if;
    logic                          valid;
    logic                          ready;
    logic [mtwd_pkg::OP_W-1:0]     op;
    logic [mtwd_pkg::SLOT_W-1:0]   task_id;
    logic                          watch_on;

    modport source (output valid, output op, output task_id, output watch_on, input ready);
    modport sink   (input valid, input op, input task_id, input watch_on, output ready);
endinterface

interface mtwd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          reset_request;
    logic [mtwd_pkg::CAUSE_W-1:0]  reset_cause;
    logic [mtwd_pkg::SLOT_W-1:0]   culprit_task;

    modport source (output valid, output reset_request, output reset_cause,
                    output culprit_task, input ready);
    modport sink   (input valid, input reset_request, input reset_cause,
                    input culprit_task, output ready);
endinterface

// ===== rtl/core/mtwd_task_bank.sv =====
// ----------------------------------------------------------------------------
// Task slot bank
// Watch flag and saturating tick counter for every task slot, with the
// per-slot timeout compare on the incremented count.
// ----------------------------------------------------------------------------
module mtwd_task_bank #(
    parameter int TASK_COUNT = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtwd_pkg::cmd_t              cmd,
    input  logic [mtwd_pkg::CNT_W-1:0]  timeout,
    output logic [TASK_COUNT-1:0]       hit
);

    for (genvar i = 0; i < TASK_COUNT; i++) begin : g_slot
        logic                       watch_reg;
        logic [mtwd_pkg::CNT_W-1:0] cnt_reg;
        logic [mtwd_pkg::CNT_W-1:0] cnt_next;
        logic                       sel;

        // Slots beyond the 3-bit address range are never selected.
        assign sel = (32'(cmd.slot) == i);

        // Saturating increment used on a tick.
        assign cnt_next = (cnt_reg == mtwd_pkg::CNT_MAX) ? cnt_reg
                                                         : cnt_reg + 16'd1;

        // A watched slot times out when its new count passes the limit.
        assign hit[i] = cmd.tick && watch_reg && (cnt_next > timeout);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                watch_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (sel && cmd.arm)
            begin
                watch_reg <= cmd.watch_on;
                cnt_reg   <= '0;
            end
            else if (sel && cmd.kick)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.tick && watch_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ===== rtl/core/mtwd_uptime.sv =====
// ----------------------------------------------------------------------------
// Uptime counter
// Free-running saturating tick count and the periodic self reset compare.
// ----------------------------------------------------------------------------
module mtwd_uptime (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  logic                           enable,
    input  logic [mtwd_pkg::UPTIME_W-1:0]  limit,
    output logic                           self_hit
);

    logic [mtwd_pkg::UPTIME_W-1:0] uptime_reg;
    logic [mtwd_pkg::UPTIME_W-1:0] uptime_next;

    // Saturating increment; the compare uses the count after this tick.
    assign uptime_next = (uptime_reg == mtwd_pkg::UPTIME_MAX) ? uptime_reg
                                                              : uptime_reg + 24'd1;
    assign self_hit    = tick && enable && (uptime_next >= limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uptime_reg <= '0;
        end
        else if (tick)
        begin
            uptime_reg <= uptime_next;
        end
    end

endmodule

// ===== rtl/core/multi_task_watchdog_monitor.sv =====
// ----------------------------------------------------------------------------
// Multi-task watchdog monitor
// Per-task liveness watchdog with a periodic self reset request.
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle unless the result side
// stalls, and returns exactly one result item for each: the item is captured
// in an input register, then all task counters, the uptime counter and the
// lowest-index timeout search are updated in one pass, and the result lands
// in an output register. Arm and kick items and the unused operation code give
// an all-zero result. A tick raises a task timeout for the lowest watched
// slot whose count exceeds the timeout, or else, if enabled, a self reset once
// the uptime count reaches its limit. Requests repeat on every later tick
// until a system reset or, for a timeout, a kick or arm of its slot. Configuration
// writes take effect on the next cycle and must be made while idle.
// ----------------------------------------------------------------------------
`include "multi_task_watchdog_monitor_assert.svh"

module multi_task_watchdog_monitor #(
    parameter int TASK_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mtwd_event_if.sink                       events,
    mtwd_result_if.source                    results,
    input  logic                             cfg_we,
    input  logic [mtwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtwd_pkg::CFG_DAT_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [mtwd_pkg::CNT_W-1:0]    timeout_reg;
    logic [mtwd_pkg::UPTIME_W-1:0] self_ticks_reg;
    logic                          self_en_reg;

    // Input stage.
    logic                          s1_valid_reg;
    logic [mtwd_pkg::OP_W-1:0]     s1_op_reg;
    logic [mtwd_pkg::SLOT_W-1:0]   s1_slot_reg;
    logic                          s1_watch_reg;
    logic                          s1_advance;

    // Result stage.
    logic                          out_valid_reg;
    logic                          out_req_reg;
    logic [mtwd_pkg::CAUSE_W-1:0]  out_cause_reg;
    logic [mtwd_pkg::SLOT_W-1:0]   out_culprit_reg;
    logic                          out_req_next;
    logic [mtwd_pkg::CAUSE_W-1:0]  out_cause_next;
    logic [mtwd_pkg::SLOT_W-1:0]   out_culprit_next;

    mtwd_pkg::cmd_t                cmd;
    logic [TASK_COUNT-1:0]         hit;
    logic                          self_hit;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= mtwd_pkg::TIMEOUT_RESET;
            self_ticks_reg <= mtwd_pkg::SELF_TICKS_RESET;
            self_en_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtwd_pkg::CFG_TASK_TIMEOUT: timeout_reg    <= cfg_data[mtwd_pkg::CNT_W-1:0];
                mtwd_pkg::CFG_SELF_TICKS:   self_ticks_reg <= cfg_data;
                mtwd_pkg::CFG_SELF_ENABLE:  self_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on when the result register is free
    // or is being emptied in the same cycle.
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || results.ready);
    assign events.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            s1_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            s1_op_reg    <= events.op;
            s1_slot_reg  <= events.task_id;
            s1_watch_reg <= events.watch_on;
        end
    end

    // Decode the item being processed this cycle.
    always_comb
    begin
        cmd          = '0;
        cmd.slot     = s1_slot_reg;
        cmd.watch_on = s1_watch_reg;
        if (s1_advance)
        begin
            case (s1_op_reg)
                mtwd_pkg::OP_ARM:  cmd.arm  = 1'b1;
                mtwd_pkg::OP_KICK: cmd.kick = 1'b1;
                mtwd_pkg::OP_TICK: cmd.tick = 1'b1;
                default: ;
            endcase
        end
    end

    mtwd_task_bank #(
        .TASK_COUNT (TASK_COUNT)
    ) u_task_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .timeout (timeout_reg),
        .hit     (hit)
    );

    mtwd_uptime u_uptime (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (cmd.tick),
        .enable   (self_en_reg),
        .limit    (self_ticks_reg),
        .self_hit (self_hit)
    );

    // Lowest timed-out slot wins; a timeout takes precedence over self reset.
    always_comb
    begin
        out_req_next     = 1'b0;
        out_cause_next   = mtwd_pkg::CAUSE_NONE;
        out_culprit_next = '0;
        for (int i = TASK_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                out_culprit_next = mtwd_pkg::SLOT_W'(i);
            end
        end
        if (|hit)
        begin
            out_req_next   = 1'b1;
            out_cause_next = mtwd_pkg::CAUSE_TIMEOUT;
        end
        else if (self_hit)
        begin
            out_req_next   = 1'b1;
            out_cause_next = mtwd_pkg::CAUSE_SELF;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_req_reg     <= out_req_next;
            out_cause_reg   <= out_cause_next;
            out_culprit_reg <= out_culprit_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.reset_request = out_req_reg;
    assign results.reset_cause   = out_cause_reg;
    assign results.culprit_task  = out_culprit_reg;

    // A request always carries a cause, and no cause means no request.
    `MTWD_ASSERT_NOW(a_req_matches_cause, out_valid_reg,
        out_req_reg == (out_cause_reg != mtwd_pkg::CAUSE_NONE))
    // A culprit is only named for a task timeout.
    `MTWD_ASSERT_NOW(a_culprit_only_on_timeout,
        out_valid_reg && (out_cause_reg != mtwd_pkg::CAUSE_TIMEOUT),
        out_culprit_reg == '0)
    // Every processed item is presented on the next cycle.
    `MTWD_ASSERT_NEXT(a_item_reaches_output, s1_advance, out_valid_reg)
    // Only a tick can raise a reset request.
    `MTWD_ASSERT_NEXT(a_no_request_without_tick,
        s1_advance && (s1_op_reg != mtwd_pkg::OP_TICK), !out_req_reg)

endmodule
